@@ hdl/sit_pkg.sv @@
// shared types, constants and helpers for the segment intersection test
// no dependencies; compiled first
package sit_pkg;

  localparam int COORD_BITS_DEF = 16;
  // wide enough for any coordinate width up to 31 bits
  localparam int CMP_BITS       = 32;

  // sign of one orientation cross product
  typedef struct packed {
    logic gt;
    logic lt;
  } sgn_t;

  typedef struct packed {
    sgn_t abc;
    sgn_t abd;
    sgn_t cda;
    sgn_t cdb;
  } orient_t;

  // lexicographic relations of the sorted endpoints
  typedef struct packed {
    logic swap_cd;
    logic b_lt_c;
    logic d_lt_a;
  } lex_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // lexicographic p < q, x first then y
  function automatic logic pless(input logic signed [CMP_BITS-1:0] px, py, qx, qy);
    return (px < qx) || ((px == qx) && (py < qy));
  endfunction

  function automatic logic is_zero(input sgn_t s);
    return !(s.gt || s.lt);
  endfunction

endpackage

@@ hdl/sit_if.sv @@
// valid/ready channel interfaces for the segment intersection test
// depends on sit_pkg
interface sit_in_if #(parameter int W = sit_pkg::COORD_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] ax;
  logic signed [W-1:0] ay;
  logic signed [W-1:0] bx;
  logic signed [W-1:0] by;
  logic signed [W-1:0] cx;
  logic signed [W-1:0] cy;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;

  modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sit_out_if #(parameter int W = sit_pkg::COORD_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic                intersects;
  logic                overlap_valid;
  logic signed [W-1:0] overlap_x;
  logic signed [W-1:0] overlap_y;

  modport source (output valid, intersects, overlap_valid, overlap_x, overlap_y,
                  input ready);
  modport sink   (input valid, intersects, overlap_valid, overlap_x, overlap_y,
                  output ready);
endinterface

@@ hdl/segment_intersection_test.sv @@
// top level of the 2-d segment intersection test: four-stage pipeline
// depends on sit_pkg, sit_if, sit_prep, sit_orient, sit_decide
//
//   channel    direction  handshake          payload
//   in_chan    sink       valid/ready        ax ay bx by cx cy dx dy (COORD_BITS each)
//   out_chan   source     valid/ready        intersects overlap_valid overlap_x overlap_y
//
// one query per cycle sustained while out_chan.ready holds; a result passes
// through the four register stages: differences and sort, the eight
// (2*COORD_BITS+2)-bit products, their compares, and the final decision
// reset clears the stage valid bits only; payload registers are not reset
// each stage loads when it is empty or the stage after it moves, so bubbles
// fill; in_chan.ready drops only when all stages hold items and out is stalled
module segment_intersection_test #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_chan,
  sit_out_if.source out_chan
);
  import sit_pkg::*;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r;
  stage_en_t en;

  // stage 1 -> stage 2
  logic signed [COORD_BITS:0]   abx, aby, acx, acy, adx, ady;
  logic signed [COORD_BITS:0]   cdx, cdy, cax, cay, cbx, cby;
  logic signed [COORD_BITS-1:0] lo_ax, lo_ay, hi_bx, hi_by;
  logic signed [COORD_BITS-1:0] lo_cx, lo_cy, hi_dx, hi_dy;
  logic                         swap_cd;

  // stage 3 -> stage 4
  orient_t                      ori;
  lex_t                         lex;
  logic signed [COORD_BITS-1:0] sp_x, sp_y;

  // result register
  logic                         intersects, overlap_valid;
  logic signed [COORD_BITS-1:0] overlap_x, overlap_y;

  // backpressure chain from the output toward the input
  always_comb begin
    en.s4 = !v4_r || out_chan.ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_chan.ready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_chan.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  // differences for the four cross products, endpoints sorted per segment
  sit_prep #(.W(COORD_BITS)) u_prep (
    .clk       (clk),
    .en        (en),
    .ax        (in_chan.ax),
    .ay        (in_chan.ay),
    .bx        (in_chan.bx),
    .by        (in_chan.by),
    .cx        (in_chan.cx),
    .cy        (in_chan.cy),
    .dx        (in_chan.dx),
    .dy        (in_chan.dy),
    .abx_r     (abx),
    .aby_r     (aby),
    .acx_r     (acx),
    .acy_r     (acy),
    .adx_r     (adx),
    .ady_r     (ady),
    .cdx_r     (cdx),
    .cdy_r     (cdy),
    .cax_r     (cax),
    .cay_r     (cay),
    .cbx_r     (cbx),
    .cby_r     (cby),
    .lo_ax_r   (lo_ax),
    .lo_ay_r   (lo_ay),
    .hi_bx_r   (hi_bx),
    .hi_by_r   (hi_by),
    .lo_cx_r   (lo_cx),
    .lo_cy_r   (lo_cy),
    .hi_dx_r   (hi_dx),
    .hi_dy_r   (hi_dy),
    .swap_cd_r (swap_cd)
  );

  // products in stage 2, signs in stage 3
  sit_orient #(.W(COORD_BITS)) u_orient (
    .clk     (clk),
    .en      (en),
    .abx     (abx),
    .aby     (aby),
    .acx     (acx),
    .acy     (acy),
    .adx     (adx),
    .ady     (ady),
    .cdx     (cdx),
    .cdy     (cdy),
    .cax     (cax),
    .cay     (cay),
    .cbx     (cbx),
    .cby     (cby),
    .lo_ax   (lo_ax),
    .lo_ay   (lo_ay),
    .hi_bx   (hi_bx),
    .hi_by   (hi_by),
    .lo_cx   (lo_cx),
    .lo_cy   (lo_cy),
    .hi_dx   (hi_dx),
    .hi_dy   (hi_dy),
    .swap_cd (swap_cd),
    .ori_r   (ori),
    .lex_r   (lex),
    .sp_x_r  (sp_x),
    .sp_y_r  (sp_y)
  );

  // final decision, doubles as the output register
  sit_decide #(.W(COORD_BITS)) u_decide (
    .clk             (clk),
    .en              (en),
    .ori             (ori),
    .lex             (lex),
    .sp_x            (sp_x),
    .sp_y            (sp_y),
    .intersects_r    (intersects),
    .overlap_valid_r (overlap_valid),
    .overlap_x_r     (overlap_x),
    .overlap_y_r     (overlap_y)
  );

  assign out_chan.valid         = v4_r;
  assign out_chan.intersects    = intersects;
  assign out_chan.overlap_valid = overlap_valid;
  assign out_chan.overlap_x     = overlap_x;
  assign out_chan.overlap_y     = overlap_y;

  // shared point is zero whenever no overlap is reported
  a_point_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.overlap_valid) |->
      (out_chan.overlap_x == '0 && out_chan.overlap_y == '0))
    else $error("shared point nonzero without overlap");

  // input is held off only when the whole pipe is full behind a stalled output
  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (v1_r && v2_r && v3_r && v4_r && !out_chan.ready))
    else $error("input stalled with room in the pipeline");

  // an unstalled transfer reaches the output after passing through every stage register
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready ##1 out_chan.ready ##1 out_chan.ready
      ##1 out_chan.ready) |=> out_chan.valid)
    else $error("result missing after pipeline latency");

endmodule

@@ hdl/sit_prep.sv @@
// stage 1: coordinate differences and lexicographic endpoint sort
// depends on sit_pkg
module sit_prep #(
  parameter int W = sit_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  sit_pkg::stage_en_t  en,
  input  logic signed [W-1:0] ax,
  input  logic signed [W-1:0] ay,
  input  logic signed [W-1:0] bx,
  input  logic signed [W-1:0] by,
  input  logic signed [W-1:0] cx,
  input  logic signed [W-1:0] cy,
  input  logic signed [W-1:0] dx,
  input  logic signed [W-1:0] dy,
  output logic signed [W:0]   abx_r,
  output logic signed [W:0]   aby_r,
  output logic signed [W:0]   acx_r,
  output logic signed [W:0]   acy_r,
  output logic signed [W:0]   adx_r,
  output logic signed [W:0]   ady_r,
  output logic signed [W:0]   cdx_r,
  output logic signed [W:0]   cdy_r,
  output logic signed [W:0]   cax_r,
  output logic signed [W:0]   cay_r,
  output logic signed [W:0]   cbx_r,
  output logic signed [W:0]   cby_r,
  output logic signed [W-1:0] lo_ax_r,
  output logic signed [W-1:0] lo_ay_r,
  output logic signed [W-1:0] hi_bx_r,
  output logic signed [W-1:0] hi_by_r,
  output logic signed [W-1:0] lo_cx_r,
  output logic signed [W-1:0] lo_cy_r,
  output logic signed [W-1:0] hi_dx_r,
  output logic signed [W-1:0] hi_dy_r,
  output logic                swap_cd_r
);
  import sit_pkg::*;

  localparam int DW = W + 1;

  logic swap_ab;
  logic swap_cd;

  function automatic logic signed [W:0] diff(input logic signed [W-1:0] p, q);
    return DW'(p) - DW'(q);
  endfunction

  always_comb begin
    swap_ab = pless(CMP_BITS'(bx), CMP_BITS'(by), CMP_BITS'(ax), CMP_BITS'(ay));
    swap_cd = pless(CMP_BITS'(dx), CMP_BITS'(dy), CMP_BITS'(cx), CMP_BITS'(cy));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      abx_r     <= diff(bx, ax);
      aby_r     <= diff(by, ay);
      acx_r     <= diff(cx, ax);
      acy_r     <= diff(cy, ay);
      adx_r     <= diff(dx, ax);
      ady_r     <= diff(dy, ay);
      cdx_r     <= diff(dx, cx);
      cdy_r     <= diff(dy, cy);
      cax_r     <= diff(ax, cx);
      cay_r     <= diff(ay, cy);
      cbx_r     <= diff(bx, cx);
      cby_r     <= diff(by, cy);
      lo_ax_r   <= swap_ab ? bx : ax;
      lo_ay_r   <= swap_ab ? by : ay;
      hi_bx_r   <= swap_ab ? ax : bx;
      hi_by_r   <= swap_ab ? ay : by;
      lo_cx_r   <= swap_cd ? dx : cx;
      lo_cy_r   <= swap_cd ? dy : cy;
      hi_dx_r   <= swap_cd ? cx : dx;
      hi_dy_r   <= swap_cd ? cy : dy;
      swap_cd_r <= swap_cd;
    end
  end

endmodule

@@ hdl/sit_orient.sv @@
// stages 2 and 3: cross product terms, then their signs; also the
// interval relations and candidate shared point. depends on sit_pkg
module sit_orient #(
  parameter int W = sit_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  sit_pkg::stage_en_t  en,
  input  logic signed [W:0]   abx,
  input  logic signed [W:0]   aby,
  input  logic signed [W:0]   acx,
  input  logic signed [W:0]   acy,
  input  logic signed [W:0]   adx,
  input  logic signed [W:0]   ady,
  input  logic signed [W:0]   cdx,
  input  logic signed [W:0]   cdy,
  input  logic signed [W:0]   cax,
  input  logic signed [W:0]   cay,
  input  logic signed [W:0]   cbx,
  input  logic signed [W:0]   cby,
  input  logic signed [W-1:0] lo_ax,
  input  logic signed [W-1:0] lo_ay,
  input  logic signed [W-1:0] hi_bx,
  input  logic signed [W-1:0] hi_by,
  input  logic signed [W-1:0] lo_cx,
  input  logic signed [W-1:0] lo_cy,
  input  logic signed [W-1:0] hi_dx,
  input  logic signed [W-1:0] hi_dy,
  input  logic                swap_cd,
  output sit_pkg::orient_t    ori_r,
  output sit_pkg::lex_t       lex_r,
  output logic signed [W-1:0] sp_x_r,
  output logic signed [W-1:0] sp_y_r
);
  import sit_pkg::*;

  localparam int PW = 2 * W + 2;

  // stage 2 registers
  logic signed [PW-1:0] l_abc_r, r_abc_r, l_abd_r, r_abd_r;
  logic signed [PW-1:0] l_cda_r, r_cda_r, l_cdb_r, r_cdb_r;
  lex_t                 lex2_r;
  logic signed [W-1:0]  sp2_x_r, sp2_y_r;

  logic a_lt_c;

  always_comb begin
    a_lt_c = pless(CMP_BITS'(lo_ax), CMP_BITS'(lo_ay), CMP_BITS'(lo_cx), CMP_BITS'(lo_cy));
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      l_abc_r        <= PW'(abx) * PW'(acy);
      r_abc_r        <= PW'(aby) * PW'(acx);
      l_abd_r        <= PW'(abx) * PW'(ady);
      r_abd_r        <= PW'(aby) * PW'(adx);
      l_cda_r        <= PW'(cdx) * PW'(cay);
      r_cda_r        <= PW'(cdy) * PW'(cax);
      l_cdb_r        <= PW'(cdx) * PW'(cby);
      r_cdb_r        <= PW'(cdy) * PW'(cbx);
      lex2_r.swap_cd <= swap_cd;
      lex2_r.b_lt_c  <= pless(CMP_BITS'(hi_bx), CMP_BITS'(hi_by),
                              CMP_BITS'(lo_cx), CMP_BITS'(lo_cy));
      lex2_r.d_lt_a  <= pless(CMP_BITS'(hi_dx), CMP_BITS'(hi_dy),
                              CMP_BITS'(lo_ax), CMP_BITS'(lo_ay));
      // larger of the two lower endpoints
      sp2_x_r        <= a_lt_c ? lo_cx : lo_ax;
      sp2_y_r        <= a_lt_c ? lo_cy : lo_ay;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ori_r.abc.gt <= l_abc_r > r_abc_r;
      ori_r.abc.lt <= l_abc_r < r_abc_r;
      ori_r.abd.gt <= l_abd_r > r_abd_r;
      ori_r.abd.lt <= l_abd_r < r_abd_r;
      ori_r.cda.gt <= l_cda_r > r_cda_r;
      ori_r.cda.lt <= l_cda_r < r_cda_r;
      ori_r.cdb.gt <= l_cdb_r > r_cdb_r;
      ori_r.cdb.lt <= l_cdb_r < r_cdb_r;
      lex_r        <= lex2_r;
      sp_x_r       <= sp2_x_r;
      sp_y_r       <= sp2_y_r;
    end
  end

endmodule

@@ hdl/sit_decide.sv @@
// stage 4: combines orientation signs and interval relations into the result
// depends on sit_pkg
module sit_decide #(
  parameter int W = sit_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  sit_pkg::stage_en_t  en,
  input  sit_pkg::orient_t    ori,
  input  sit_pkg::lex_t       lex,
  input  logic signed [W-1:0] sp_x,
  input  logic signed [W-1:0] sp_y,
  output logic                intersects_r,
  output logic                overlap_valid_r,
  output logic signed [W-1:0] overlap_x_r,
  output logic signed [W-1:0] overlap_y_r
);
  import sit_pkg::*;

  logic sab_zero, scd_zero, sab_le0, scd_le0;
  logic disjoint, hit, ovl;

  always_comb begin
    sab_zero = is_zero(ori.abc) || is_zero(ori.abd);
    scd_zero = is_zero(ori.cda) || is_zero(ori.cdb);
    // both nonzero: the product is negative when the signs differ
    sab_le0  = sab_zero || (ori.abc.gt ^ ori.abd.gt);
    scd_le0  = scd_zero || (ori.cda.gt ^ ori.cdb.gt);
    disjoint = lex.b_lt_c || lex.d_lt_a;
    hit      = (sab_zero && scd_zero) ? !disjoint : (sab_le0 && scd_le0);
    // lower endpoint of cd on line ab
    ovl      = (lex.swap_cd ? is_zero(ori.abd) : is_zero(ori.abc)) && !disjoint;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      intersects_r    <= hit;
      overlap_valid_r <= ovl;
      overlap_x_r     <= ovl ? sp_x : '0;
      overlap_y_r     <= ovl ? sp_y : '0;
    end
  end

endmodule
